// File: src/rbc_pkg.sv
// ----------------------------------------------------------------------------
// rbc_pkg
// shared widths, character constants, error codes and digit helpers of the
// radix base converter
// ----------------------------------------------------------------------------
package rbc_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned BASE_W  = 6;
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned ERR_W   = 2;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_NULL    = 8'h00;

  localparam logic [DIGIT_W-1:0] DIGIT_INVALID = 6'd63;
  localparam logic [DIGIT_W-1:0] DEC_RADIX     = 6'd10;
  localparam logic [BASE_W-1:0]  BASE_MIN      = 6'd2;
  localparam logic [BASE_W-1:0]  BASE_MAX      = 6'd36;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_BAD_DIGIT = 2'd2
  } rbc_err_e;

  // digit stack port controls
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } rbc_mem_ctl_t;

  // ascii character to digit value, invalid characters never below a base
  function automatic logic [DIGIT_W-1:0] char_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] diff;
    diff = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      diff = c - CHAR_ZERO;
      return diff[DIGIT_W-1:0];
    end
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      diff = c - CHAR_UPPER_A;
      return diff[DIGIT_W-1:0] + DEC_RADIX;
    end
    return DIGIT_INVALID;
  endfunction

  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    if (b < BASE_MIN) return BASE_MIN;
    if (b > BASE_MAX) return BASE_MAX;
    return b;
  endfunction

  // digit value 0..35 to '0'-'9', 'A'-'Z'
  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] r);
    logic [DIGIT_W-1:0] above;
    above = r - DEC_RADIX;
    if (r < DEC_RADIX) return CHAR_ZERO + CHAR_W'(r);
    return CHAR_UPPER_A + CHAR_W'(above);
  endfunction

endpackage

// File: src/rbc_if.sv
// ----------------------------------------------------------------------------
// rbc_if
// valid/ready channels of the radix base converter: digit input and result
// ----------------------------------------------------------------------------
interface rbc_in_if;
  logic                            valid;
  logic                            ready;
  logic [rbc_pkg::CHAR_W-1:0]      digit_char;
  logic                            is_last;
  logic [rbc_pkg::BASE_W-1:0]      source_base;
  logic [rbc_pkg::BASE_W-1:0]      dest_base;

  modport source (output valid, output digit_char, output is_last,
                  output source_base, output dest_base, input ready);
  modport sink   (input valid, input digit_char, input is_last,
                  input source_base, input dest_base, output ready);
endinterface

interface rbc_out_if;
  logic                            valid;
  logic                            ready;
  logic [rbc_pkg::CHAR_W-1:0]      out_char;
  logic                            out_last;
  logic [rbc_pkg::ERR_W-1:0]       error_code;

  modport source (output valid, output out_char, output out_last,
                  output error_code, input ready);
  modport sink   (input valid, input out_char, input out_last,
                  input error_code, output ready);
endinterface

// File: src/rbc_divider.sv
// ----------------------------------------------------------------------------
// rbc_divider
// iterative divide of a value by a small base, eight quotient bits a cycle
// ----------------------------------------------------------------------------
module rbc_divider #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [VALUE_BITS-1:0]            dividend_i,
  input  logic [rbc_pkg::BASE_W-1:0]       divisor_i,
  output logic                             done_o,
  output logic [VALUE_BITS-1:0]            quotient_o,
  output logic [rbc_pkg::DIGIT_W-1:0]      remainder_o
);

  localparam int unsigned BITS_PER_STEP = 8;
  localparam int unsigned NSTEP = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int unsigned PAD_W = NSTEP * BITS_PER_STEP;
  localparam int unsigned CW    = $clog2(NSTEP + 1);

  logic                        busy_q;
  logic                        done_q;
  logic [CW-1:0]               cnt_q;
  logic [PAD_W-1:0]            work_q;
  logic [rbc_pkg::DIGIT_W-1:0] rem_q;
  logic [rbc_pkg::BASE_W-1:0]  div_q;

  logic [PAD_W-1:0]            work_d;
  logic [rbc_pkg::DIGIT_W-1:0] rem_d;

  // restoring division, remainder stays below the divisor
  always_comb begin
    logic [rbc_pkg::DIGIT_W:0] t;
    t      = '0;
    rem_d  = rem_q;
    work_d = work_q;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      t      = {rem_d, work_d[PAD_W-1]};
      work_d = {work_d[PAD_W-2:0], 1'b0};
      if (t >= {1'b0, div_q}) begin
        t         = t - {1'b0, div_q};
        work_d[0] = 1'b1;
      end
      rem_d = t[rbc_pkg::DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      work_q <= '0;
      rem_q  <= '0;
      div_q  <= rbc_pkg::BASE_MIN;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        work_q <= PAD_W'(dividend_i);
        rem_q  <= '0;
        div_q  <= divisor_i;
      end else if (busy_q) begin
        work_q <= work_d;
        rem_q  <= rem_d;
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == CW'(NSTEP - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = work_q[VALUE_BITS-1:0];
  assign remainder_o = rem_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < div_q))
    else $error("remainder not below divisor");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("done without a division in flight");

  a_no_start_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i)
    else $error("division restarted while busy");

endmodule

// File: src/rbc_digit_stack.sv
// ----------------------------------------------------------------------------
// rbc_digit_stack
// remainder store, one write and one registered read port
// ----------------------------------------------------------------------------
module rbc_digit_stack #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                          clk_i,
  input  rbc_pkg::rbc_mem_ctl_t         ctl_i,
  input  logic [$clog2(DEPTH)-1:0]      waddr_i,
  input  logic [rbc_pkg::DIGIT_W-1:0]   wdata_i,
  input  logic [$clog2(DEPTH)-1:0]      raddr_i,
  output logic [rbc_pkg::DIGIT_W-1:0]   rdata_o
);

  logic [rbc_pkg::DIGIT_W-1:0] mem [DEPTH];
  logic [rbc_pkg::DIGIT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/radix_base_converter.sv
// ----------------------------------------------------------------------------
// radix_base_converter
// converts a string of ascii digits from a source base to a destination base
// ----------------------------------------------------------------------------
// operation: input digits are taken only in the accumulate state; after the last
//   digit each result digit comes from the 8-bit-a-cycle divide loop of the
//   divider and is pushed on the stack, then popped through the read and load states
// one number at a time; an error result goes out as a single item
// reset: clears accumulator, count, error and handshakes; stack needs no clearing
module radix_base_converter #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned MAX_DIGITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rbc_in_if.sink     in_i,
  rbc_out_if.source  out_o
);

  localparam int unsigned AW    = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int unsigned MAC_W = VALUE_BITS + rbc_pkg::BASE_W + 1;

  typedef enum logic [2:0] {
    ST_ACCUM,   // taking digits
    ST_DIV,     // dividing, pushing remainders
    ST_RD,      // stack read issued
    ST_LOAD,    // stack data into the output register
    ST_ERR      // single error item
  } state_e;

  state_e                        state_q;
  logic [VALUE_BITS-1:0]         acc_q;
  rbc_pkg::rbc_err_e             err_q;
  logic [CNT_W-1:0]              count_q;
  logic [rbc_pkg::BASE_W-1:0]    db_q;
  logic                          div_start_q;
  logic [VALUE_BITS-1:0]         div_val_q;

  // output register
  logic                          out_valid_q;
  logic [rbc_pkg::CHAR_W-1:0]    out_char_q;
  logic                          out_last_q;
  rbc_pkg::rbc_err_e             out_err_q;

  // digit accumulation
  logic [rbc_pkg::DIGIT_W-1:0]   digit;
  logic [rbc_pkg::BASE_W-1:0]    sb;
  logic [rbc_pkg::BASE_W-1:0]    db;
  logic [MAC_W-1:0]              mac;
  logic                          digit_bad;
  logic                          acc_ovf;
  logic [VALUE_BITS-1:0]         acc_next;
  rbc_pkg::rbc_err_e             err_next;
  logic                          in_fire;
  logic                          out_free;
  logic                          out_load;

  // divider and stack
  logic                          div_done;
  logic [VALUE_BITS-1:0]         div_quot;
  logic [rbc_pkg::DIGIT_W-1:0]   div_rem;
  logic [CNT_W-1:0]              count_inc;
  logic [CNT_W-1:0]              count_dec;
  rbc_pkg::rbc_mem_ctl_t         mem_ctl;
  logic [rbc_pkg::DIGIT_W-1:0]   stack_rdata;

  assign digit     = rbc_pkg::char_value(in_i.digit_char);
  assign sb        = rbc_pkg::clamp_base(in_i.source_base);
  assign db        = rbc_pkg::clamp_base(in_i.dest_base);
  // acc * base + digit, anything above the value width is an overflow
  assign mac       = MAC_W'(acc_q) * MAC_W'(sb) + MAC_W'(digit);
  assign digit_bad = (digit >= sb);
  assign acc_ovf   = |mac[MAC_W-1:VALUE_BITS];
  assign acc_next  = (digit_bad || acc_ovf) ? acc_q : mac[VALUE_BITS-1:0];

  // first error of the number wins
  always_comb begin
    err_next = err_q;
    if (err_q == rbc_pkg::ERR_NONE) begin
      if (digit_bad) begin
        err_next = rbc_pkg::ERR_BAD_DIGIT;
      end else if (acc_ovf) begin
        err_next = rbc_pkg::ERR_OVERFLOW;
      end
    end
  end

  assign in_i.ready = (state_q == ST_ACCUM);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  // a new item enters the output register this cycle
  assign out_load   = out_free && ((state_q == ST_LOAD) || (state_q == ST_ERR));

  assign count_inc  = count_q + 1'b1;
  assign count_dec  = count_q - 1'b1;

  // push on each remainder, pop one digit per read
  always_comb begin
    mem_ctl.wr_en = (state_q == ST_DIV) && div_done;
    mem_ctl.rd_en = (state_q == ST_RD);
  end

  rbc_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start_q),
    .dividend_i  (div_val_q),
    .divisor_i   (db_q),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  rbc_digit_stack #(
    .DEPTH (MAX_DIGITS)
  ) u_digit_stack (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (div_rem),
    .raddr_i (count_dec[AW-1:0]),
    .rdata_o (stack_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      acc_q       <= '0;
      err_q       <= rbc_pkg::ERR_NONE;
      count_q     <= '0;
      db_q        <= rbc_pkg::BASE_MIN;
      div_start_q <= 1'b0;
      div_val_q   <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= rbc_pkg::CHAR_NULL;
      out_last_q  <= 1'b0;
      out_err_q   <= rbc_pkg::ERR_NONE;
    end else begin
      div_start_q <= 1'b0;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_ACCUM: begin
          if (in_fire) begin
            if (!in_i.is_last) begin
              acc_q <= acc_next;
              err_q <= err_next;
            end else begin
              // end of number: accumulator clears on every path
              acc_q   <= '0;
              count_q <= '0;
              err_q   <= err_next;
              if (err_next != rbc_pkg::ERR_NONE) begin
                state_q <= ST_ERR;
              end else begin
                db_q        <= db;
                div_val_q   <= acc_next;
                div_start_q <= 1'b1;
                state_q     <= ST_DIV;
              end
            end
          end
        end

        ST_DIV: begin
          if (div_done) begin
            count_q <= count_inc;
            if (div_quot == '0) begin
              state_q <= ST_RD;
            end else if (count_inc == CNT_W'(MAX_DIGITS)) begin
              // result would not fit in the stack
              err_q   <= rbc_pkg::ERR_OVERFLOW;
              state_q <= ST_ERR;
            end else begin
              div_val_q   <= div_quot;
              div_start_q <= 1'b1;
            end
          end
        end

        ST_RD: begin
          count_q <= count_dec;
          state_q <= ST_LOAD;
        end

        ST_LOAD: begin
          // read data holds until the next read, so waiting is safe
          if (out_free) begin
            out_char_q  <= rbc_pkg::digit_ascii(stack_rdata);
            out_last_q  <= (count_q == '0);
            out_err_q   <= rbc_pkg::ERR_NONE;
            state_q     <= (count_q == '0) ? ST_ACCUM : ST_RD;
          end
        end

        ST_ERR: begin
          if (out_free) begin
            out_char_q  <= rbc_pkg::CHAR_NULL;
            out_last_q  <= 1'b1;
            out_err_q   <= err_q;
            err_q       <= rbc_pkg::ERR_NONE;
            state_q     <= ST_ACCUM;
          end
        end

        default: begin
          state_q <= ST_ACCUM;
        end
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_char   = out_char_q;
  assign out_o.out_last   = out_last_q;
  assign out_o.error_code = out_err_q;

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_DIGITS))
    else $error("digit count beyond stack depth");

  a_done_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider result outside the divide phase");

  a_acc_cleared_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.is_last) |=> (acc_q == '0))
    else $error("accumulator not cleared after last digit");

  a_error_item_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_err_q != rbc_pkg::ERR_NONE))
      |-> (out_last_q && (out_char_q == rbc_pkg::CHAR_NULL)))
    else $error("error item not a single null last item");

  a_rem_below_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (div_rem < db_q))
    else $error("remainder not below destination base");

endmodule
